/* hdl/ppp_pkg.sv */
// Shared types and constants for the pixel packet parser.
package ppp_pkg;

	localparam logic [7:0]  HEADER_MAGIC  = 8'hAA;
	localparam logic [15:0] TRAILER_MAGIC = 16'hCCCC;
	localparam logic [3:0]  PATTERN_CLEAN = 4'b0000;

	typedef enum logic [1:0] {
		KIND_PIXEL   = 2'd0,
		KIND_SUMMARY = 2'd1,
		KIND_TRUNC   = 2'd2
	} kind_t;

	typedef enum logic [9:0] {
		PH_HEAD   = 10'b00_0000_0001,
		PH_DAQ    = 10'b00_0000_0010,
		PH_TID_HI = 10'b00_0000_0100,
		PH_TID_LO = 10'b00_0000_1000,
		PH_LEN_HI = 10'b00_0001_0000,
		PH_LEN_LO = 10'b00_0010_0000,
		PH_PIXEL  = 10'b00_0100_0000,
		PH_TRL_HI = 10'b00_1000_0000,
		PH_TRL_LO = 10'b01_0000_0000,
		PH_DROP   = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  daq_id;
		logic [15:0] trigger_id;
		logic        pixel_valid;
		logic [7:0]  pixel_timestamp;
		logic [8:0]  pixel_column;
		logic [9:0]  pixel_row;
		logic [3:0]  pixel_pattern;
		logic        header_ok;
		logic        trailer_ok;
		logic        pixels_ok;
		logic        packet_ok;
	} result_t;

endpackage

/* hdl/ppp_ifs.sv */
// Handshake interfaces for the packet byte stream and the parser results.
interface ppp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ppp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  daq_id;
	logic [15:0] trigger_id;
	logic        pixel_valid;
	logic [7:0]  pixel_timestamp;
	logic [8:0]  pixel_column;
	logic [9:0]  pixel_row;
	logic [3:0]  pixel_pattern;
	logic        header_ok;
	logic        trailer_ok;
	logic        pixels_ok;
	logic        packet_ok;

	modport source (
		output valid, input ready, output kind, output daq_id, output trigger_id,
		output pixel_valid, output pixel_timestamp, output pixel_column, output pixel_row,
		output pixel_pattern, output header_ok, output trailer_ok, output pixels_ok,
		output packet_ok
	);
	modport sink (
		input valid, output ready, input kind, input daq_id, input trigger_id,
		input pixel_valid, input pixel_timestamp, input pixel_column, input pixel_row,
		input pixel_pattern, input header_ok, input trailer_ok, input pixels_ok,
		input packet_ok
	);
endinterface

/* hdl/ppp_core.sv */
// Packet state machine: consumes one byte per step and forms at most one result.
module ppp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	output logic              res_valid,
	output ppp_pkg::result_t  res
);
	import ppp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [1:0]  bw_q, bw_d;
	logic [23:0] wa_q, wa_d;
	logic [7:0]  header_q, header_d;
	logic [7:0]  daq_q, daq_d;
	logic [15:0] trig_q, trig_d;
	logic [15:0] words_q, words_d;
	logic [7:0]  trl_q, trl_d;
	logic        good_q, good_d;

	logic        is_pix, is_sum, is_trunc;
	logic        hok, tok;
	logic [31:0] pix;
	logic [15:0] len_word;

	always_comb begin
		phase_d  = phase_q;
		bw_d     = bw_q;
		wa_d     = wa_q;
		header_d = header_q;
		daq_d    = daq_q;
		trig_d   = trig_q;
		words_d  = words_q;
		trl_d    = trl_q;
		good_d   = good_q;
		is_pix   = 1'b0;
		is_sum   = 1'b0;
		is_trunc = 1'b0;
		hok      = 1'b0;
		tok      = 1'b0;
		pix      = {wa_q, data_byte};
		len_word = {words_q[15:8], data_byte};

		unique case (phase_q)
			PH_HEAD: begin
				header_d = data_byte;
				daq_d    = 8'd0;
				trig_d   = 16'd0;
				words_d  = 16'd0;
				bw_d     = 2'd0;
				wa_d     = 24'd0;
				trl_d    = 8'd0;
				good_d   = 1'b1;
				phase_d  = PH_DAQ;
			end
			PH_DAQ: begin
				daq_d   = data_byte;
				phase_d = PH_TID_HI;
			end
			PH_TID_HI: begin
				trig_d  = {data_byte, 8'd0};
				phase_d = PH_TID_LO;
			end
			PH_TID_LO: begin
				trig_d  = {trig_q[15:8], data_byte};
				phase_d = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				words_d = {data_byte, 8'd0};
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				words_d = len_word;
				bw_d    = 2'd0;
				phase_d = (len_word == 16'd0) ? PH_TRL_HI : PH_PIXEL;
			end
			PH_PIXEL: begin
				if (bw_q != 2'd3) begin
					wa_d = {wa_q[15:0], data_byte};
					bw_d = bw_q + 2'd1;
				end else begin
					wa_d   = 24'd0;
					bw_d   = 2'd0;
					is_pix = 1'b1;
					if (!pix[31] || pix[3:0] != PATTERN_CLEAN) begin
						good_d = 1'b0;
					end
					words_d = words_q - 16'd1;
					if (words_q == 16'd1) begin
						phase_d = PH_TRL_HI;
					end
				end
			end
			PH_TRL_HI: begin
				trl_d   = data_byte;
				phase_d = PH_TRL_LO;
			end
			PH_TRL_LO: begin
				hok     = (header_q == HEADER_MAGIC);
				tok     = ({trl_q, data_byte} == TRAILER_MAGIC);
				is_sum  = 1'b1;
				phase_d = PH_DROP;
			end
			PH_DROP: begin
				phase_d = PH_DROP;
			end
			default: begin
				phase_d = PH_DROP;
			end
		endcase

		// The end of the buffer cuts short any packet still open.
		if (last_byte) begin
			if (!is_sum && phase_d != PH_DROP) begin
				is_trunc = 1'b1;
				is_pix   = 1'b0;
			end
			phase_d = PH_HEAD;
		end
	end

	always_comb begin
		res_valid           = is_pix || is_sum || is_trunc;
		res                 = '0;
		res.daq_id          = daq_d;
		res.trigger_id      = trig_d;
		priority if (is_trunc) begin
			res.kind = KIND_TRUNC;
		end else if (is_sum) begin
			res.kind       = KIND_SUMMARY;
			res.header_ok  = hok;
			res.trailer_ok = tok;
			res.pixels_ok  = good_d;
			res.packet_ok  = hok && tok && good_d;
		end else begin
			res.kind            = KIND_PIXEL;
			res.pixel_valid     = is_pix & pix[31];
			res.pixel_timestamp = is_pix ? pix[30:23] : 8'd0;
			res.pixel_column    = is_pix ? pix[22:14] : 9'd0;
			res.pixel_row       = is_pix ? pix[13:4] : 10'd0;
			res.pixel_pattern   = is_pix ? pix[3:0] : 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEAD;
			bw_q     <= 2'd0;
			wa_q     <= 24'd0;
			header_q <= 8'd0;
			daq_q    <= 8'd0;
			trig_q   <= 16'd0;
			words_q  <= 16'd0;
			trl_q    <= 8'd0;
			good_q   <= 1'b1;
		end else if (step) begin
			phase_q  <= phase_d;
			bw_q     <= bw_d;
			wa_q     <= wa_d;
			header_q <= header_d;
			daq_q    <= daq_d;
			trig_q   <= trig_d;
			words_q  <= words_d;
			trl_q    <= trl_d;
			good_q   <= good_d;
		end
	end

endmodule

/* hdl/pixel_packet_parser.sv */
// Pixel packet parser top level: input register, packet state machine, result register.
// A byte's result passes through the input register and then the result register before it is offered.
// Throughput: one byte per clock while the receiver takes results; the input register and the result register
// let a new byte be taken while a finished result waits to be taken.
// Reset: arst_n clears both valid flags and returns the parser to awaiting a header.
module pixel_packet_parser (
	input  logic                clk,
	input  logic                arst_n,
	ppp_byte_if.sink            bytes,
	ppp_result_if.source        results
);
	import ppp_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       out_valid_q;
	result_t    res_q;
	logic       advance;
	logic       step;
	logic       core_valid;
	result_t    core_res;

	assign advance     = !out_valid_q || results.ready;
	assign step        = valid_s1 && advance;
	assign bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			data_s1 <= bytes.data_byte;
			last_s1 <= bytes.last_byte;
		end
	end

	ppp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.res_valid (core_valid),
		.res       (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && core_valid) begin
			res_q <= core_res;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.kind            = res_q.kind;
	assign results.daq_id          = res_q.daq_id;
	assign results.trigger_id      = res_q.trigger_id;
	assign results.pixel_valid     = res_q.pixel_valid;
	assign results.pixel_timestamp = res_q.pixel_timestamp;
	assign results.pixel_column    = res_q.pixel_column;
	assign results.pixel_row       = res_q.pixel_row;
	assign results.pixel_pattern   = res_q.pixel_pattern;
	assign results.header_ok       = res_q.header_ok;
	assign results.trailer_ok      = res_q.trailer_ok;
	assign results.pixels_ok       = res_q.pixels_ok;
	assign results.packet_ok       = res_q.packet_ok;

endmodule

/* tb/ppp_scoreboard_pkg.sv */
// Scoreboard class that predicts and checks the pixel packet parser results.
package ppp_scoreboard_pkg;

	import ppp_pkg::*;

	class parse_scoreboard;
		phase_t      phase;
		logic [1:0]  word_bytes;
		logic [23:0] word_acc;
		logic [7:0]  header_byte;
		logic [7:0]  daq_byte;
		logic [15:0] trigger_word;
		logic [15:0] words_left;
		logic [7:0]  trailer_hi;
		logic        pixels_good;
		result_t     expected_q[$];
		int          checked;
		int          errors;

		function new();
			clear_packet();
			checked = 0;
			errors = 0;
		endfunction

		function void clear_packet();
			phase = PH_HEAD;
			word_bytes = '0;
			word_acc = '0;
			header_byte = '0;
			daq_byte = '0;
			trigger_word = '0;
			words_left = '0;
			trailer_hi = '0;
			pixels_good = 1'b1;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_byte(input logic [7:0] b, input logic last);
			result_t     r;
			logic [31:0] pix;
			logic        hok;
			logic        tok;
			bit          made;
			r = '0;
			pix = '0;
			hok = 1'b0;
			tok = 1'b0;
			made = 0;
			case (phase)
				PH_HEAD: begin
					clear_packet();
					header_byte = b;
					phase = PH_DAQ;
				end
				PH_DAQ: begin
					daq_byte = b;
					phase = PH_TID_HI;
				end
				PH_TID_HI: begin
					trigger_word = {b, 8'h00};
					phase = PH_TID_LO;
				end
				PH_TID_LO: begin
					trigger_word[7:0] = b;
					phase = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					words_left = {b, 8'h00};
					phase = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					words_left[7:0] = b;
					word_bytes = '0;
					phase = (words_left == 16'd0) ? PH_TRL_HI : PH_PIXEL;
				end
				PH_PIXEL: begin
					if (word_bytes < 2'd3) begin
						word_acc = {word_acc[15:0], b};
						word_bytes = word_bytes + 2'd1;
					end else begin
						pix = {word_acc, b};
						word_acc = '0;
						word_bytes = '0;
						made = 1;
						r.kind = KIND_PIXEL;
						if (!pix[31] || pix[3:0] != PATTERN_CLEAN)
							pixels_good = 1'b0;
						words_left = words_left - 16'd1;
						if (words_left == 16'd0)
							phase = PH_TRL_HI;
					end
				end
				PH_TRL_HI: begin
					trailer_hi = b;
					phase = PH_TRL_LO;
				end
				PH_TRL_LO: begin
					hok = (header_byte == HEADER_MAGIC);
					tok = ({trailer_hi, b} == TRAILER_MAGIC);
					made = 1;
					r.kind = KIND_SUMMARY;
					phase = PH_DROP;
				end
				default: begin
					phase = PH_DROP;
				end
			endcase
			// A finished summary leaves the parser discarding, so it is never replaced.
			if (last) begin
				if (phase != PH_DROP) begin
					made = 1;
					r.kind = KIND_TRUNC;
				end
				phase = PH_HEAD;
			end
			if (made) begin
				r.daq_id = daq_byte;
				r.trigger_id = trigger_word;
				if (r.kind == KIND_PIXEL) begin
					r.pixel_valid = pix[31];
					r.pixel_timestamp = pix[30:23];
					r.pixel_column = pix[22:14];
					r.pixel_row = pix[13:4];
					r.pixel_pattern = pix[3:0];
				end else if (r.kind == KIND_SUMMARY) begin
					r.header_ok = hok;
					r.trailer_ok = tok;
					r.pixels_ok = pixels_good;
					r.packet_ok = hok && tok && pixels_good;
				end
				expected_q.push_back(r);
			end
		endfunction

		task report(input string msg);
			$display("ERROR: %s", msg);
			errors++;
		endtask

		task field_check(input string name, input logic [31:0] got_v, input logic [31:0] exp_v);
			if (got_v !== exp_v)
				report($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
					checked, name, got_v, exp_v));
		endtask

		task check_result(input result_t got);
			result_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("result %0d arrived with nothing pending", checked));
			end else begin
				e = expected_q.pop_front();
				field_check("kind", 32'(got.kind), 32'(e.kind));
				field_check("daq_id", 32'(got.daq_id), 32'(e.daq_id));
				field_check("trigger_id", 32'(got.trigger_id), 32'(e.trigger_id));
				field_check("pixel_valid", 32'(got.pixel_valid), 32'(e.pixel_valid));
				field_check("pixel_timestamp", 32'(got.pixel_timestamp),
					32'(e.pixel_timestamp));
				field_check("pixel_column", 32'(got.pixel_column), 32'(e.pixel_column));
				field_check("pixel_row", 32'(got.pixel_row), 32'(e.pixel_row));
				field_check("pixel_pattern", 32'(got.pixel_pattern), 32'(e.pixel_pattern));
				field_check("header_ok", 32'(got.header_ok), 32'(e.header_ok));
				field_check("trailer_ok", 32'(got.trailer_ok), 32'(e.trailer_ok));
				field_check("pixels_ok", 32'(got.pixels_ok), 32'(e.pixels_ok));
				field_check("packet_ok", 32'(got.packet_ok), 32'(e.packet_ok));
			end
			checked++;
		endtask

		task check_drained();
			if (expected_q.size() != 0)
				report($sformatf("%0d expected results never arrived", expected_q.size()));
		endtask
	endclass

endpackage

/* tb/tb_pixel_packet_parser.sv */
// Top-level testbench for the pixel packet parser with stimulus, handshakes and checking.
module tb_pixel_packet_parser;

	timeunit 1ns;
	timeprecision 1ps;

	import ppp_pkg::*;
	import ppp_scoreboard_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_BYTES = 1450;
	localparam int QUIET_FROM = 1150;
	localparam int HOLD_CYCLES = 150;

	logic clk = 1'b0;
	logic arst_n;
	int   cycle_count = 0;
	bit   idle_on = 1;
	bit   hold_req = 0;

	parse_scoreboard sb;

	ppp_byte_if   bytes_if();
	ppp_result_if results_if();

	pixel_packet_parser u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (bytes_if),
		.results (results_if)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_t seen;
		if (arst_n && results_if.valid && results_if.ready) begin
			seen.kind = kind_t'(results_if.kind);
			seen.daq_id = results_if.daq_id;
			seen.trigger_id = results_if.trigger_id;
			seen.pixel_valid = results_if.pixel_valid;
			seen.pixel_timestamp = results_if.pixel_timestamp;
			seen.pixel_column = results_if.pixel_column;
			seen.pixel_row = results_if.pixel_row;
			seen.pixel_pattern = results_if.pixel_pattern;
			seen.header_ok = results_if.header_ok;
			seen.trailer_ok = results_if.trailer_ok;
			seen.pixels_ok = results_if.pixels_ok;
			seen.packet_ok = results_if.packet_ok;
			sb.check_result(seen);
		end
	end

	// The receiver stalls in random bursts, or for one long stretch on request.
	initial begin
		results_if.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				results_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				results_if.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				results_if.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task send_buffer(input byte_q_t bq);
		for (int i = 0; i < bq.size(); i++) begin
			if (idle_on && $urandom_range(0, 5) == 0) begin
				bytes_if.valid <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			bytes_if.valid <= 1'b1;
			bytes_if.data_byte <= bq[i];
			bytes_if.last_byte <= (i == bq.size() - 1);
			do @(posedge clk); while (!bytes_if.ready);
			sb.note_byte(bq[i], i == bq.size() - 1);
		end
	endtask

	task wait_drained();
		bytes_if.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic byte_q_t make_packet(input int n_words);
		byte_q_t     bq;
		logic [31:0] w;
		logic [15:0] trig;
		logic [15:0] trailer;
		trig = 16'($urandom());
		bq.push_back(($urandom_range(0, 9) != 0) ? HEADER_MAGIC : 8'($urandom()));
		bq.push_back(8'($urandom()));
		bq.push_back(trig[15:8]);
		bq.push_back(trig[7:0]);
		bq.push_back(8'(n_words >> 8));
		bq.push_back(8'(n_words));
		for (int i = 0; i < n_words; i++) begin
			w = $urandom();
			if ($urandom_range(0, 1) == 0) begin
				w[31] = 1'b1;
				w[3:0] = PATTERN_CLEAN;
			end
			bq.push_back(w[31:24]);
			bq.push_back(w[23:16]);
			bq.push_back(w[15:8]);
			bq.push_back(w[7:0]);
		end
		trailer = ($urandom_range(0, 6) != 0) ? TRAILER_MAGIC : 16'($urandom());
		bq.push_back(trailer[15:8]);
		bq.push_back(trailer[7:0]);
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 3)) bq.push_back(8'($urandom()));
		return bq;
	endfunction

	initial begin
		byte_q_t bq;
		int      sent;
		int      pkt;
		int      sel;
		int      n_words;
		sb = new();
		arst_n = 1'b0;
		bytes_if.valid = 1'b0;
		bytes_if.data_byte = '0;
		bytes_if.last_byte = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Good packet with one clean pixel, all-zero ids.
		send_buffer('{HEADER_MAGIC, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
			8'hFF, 8'hFF, 8'hFF, 8'hF0, 8'hCC, 8'hCC});
		// Zero word count, bad header and trailer, one byte dropped after the trailer.
		send_buffer('{8'h55, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h33, 8'hCC, 8'h12});
		// Truncation right after the DAQ id.
		send_buffer('{HEADER_MAGIC, 8'h7F});

		sent = 0;
		pkt = 0;
		while (sent < RANDOM_BYTES) begin
			if (sent > QUIET_FROM)
				idle_on = 0;
			n_words = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
			sel = $urandom_range(0, 99);
			if (pkt == 20) begin
				hold_req = 1;
				bq = make_packet(20);
			end else if (sel < 70) begin
				bq = make_packet(n_words);
			end else if (sel < 85) begin
				bq = make_packet(n_words);
				bq = bq[0:$urandom_range(1, 6 + 4 * n_words + 1) - 1];
			end else begin
				bq.delete();
				repeat ($urandom_range(1, 12)) bq.push_back(8'($urandom()));
				if ($urandom_range(0, 2) == 0)
					bq[0] = HEADER_MAGIC;
			end
			send_buffer(bq);
			sent += bq.size();
			pkt++;
			if (pkt % 60 == 40)
				wait_drained();
		end

		wait_drained();
		repeat (10) @(posedge clk);
		sb.check_drained();
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
